FILE: rtl/gbba_pkg.sv
// Package for the group bitmap block allocator.
// Sizes, codes, types and helper functions shared by all rtl files but gbba_ram.
package gbba_pkg;

  localparam int NUM_GROUPS      = 8;
  localparam int WORDS_PER_GROUP = 256;

  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;
  localparam int SIZE_W    = 14;
  localparam int CNT_W     = 14;
  localparam int AG_W      = 4;
  localparam int BLK_W     = 16;
  localparam int ACC_W     = 18;
  localparam int CFG_W     = 14;

  localparam int GRP_W    = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int GCNT_W   = ($clog2(NUM_GROUPS + 1) > AG_W) ? $clog2(NUM_GROUPS + 1) : AG_W;
  localparam int WORD_W   = (WORDS_PER_GROUP > 1) ? $clog2(WORDS_PER_GROUP) : 1;
  localparam int WCNT_W   = $clog2(WORDS_PER_GROUP + 1);
  localparam int RAM_DEPTH = NUM_GROUPS * WORDS_PER_GROUP;
  localparam int ADDR_W   = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
  localparam int CLR_W    = ADDR_W + 1;
  localparam int GROUP_CAP = WORDS_PER_GROUP * WORD_BITS;

  localparam logic [CNT_W-1:0]     COUNT_MAX = '1;
  localparam logic [WORD_BITS-1:0] ALL_ONES  = '1;

  typedef enum logic {
    REQ_ALLOC,
    REQ_FREE
  } req_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NO_SPACE,
    ST_OUT_OF_RANGE
  } status_t;

  typedef enum logic {
    CFG_GROUP_SIZE,
    CFG_ACTIVE_GROUPS
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_DIV,
    S_FREE_RD,
    S_FREE_WR,
    S_GRP,
    S_RD,
    S_CHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bit_idx;
  } scan_res_t;

  function automatic logic [ADDR_W-1:0] word_addr(logic [GRP_W-1:0] g,
                                                  logic [WORD_W-1:0] w);
    return ADDR_W'(g * WORDS_PER_GROUP) + ADDR_W'(w);
  endfunction

endpackage

FILE: rtl/gbba_if.sv
// Valid/ready channel interfaces for the block allocator.
// Depends on gbba_pkg for field widths.
interface gbba_in_if import gbba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [BLK_W-1:0] block_number;

  modport source (output valid, req_type, block_number, input ready);
  modport sink (input valid, req_type, block_number, output ready);
endinterface

interface gbba_out_if import gbba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BLK_W-1:0] allocated_block;
  logic [1:0]       status;

  modport source (output valid, allocated_block, status, input ready);
  modport sink (input valid, allocated_block, status, output ready);
endinterface

FILE: rtl/gbba_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module gbba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/gbba_alu.sv
// Shared add/subtract and compare unit of the allocator sequencer.
// Depends on gbba_pkg.
module gbba_alu import gbba_pkg::*; (
  input  logic             sub,
  input  logic [ACC_W-1:0] a,
  input  logic [ACC_W-1:0] b,
  output logic [ACC_W-1:0] res,
  output logic             ge
);

  assign res = sub ? (a - b) : (a + b);
  assign ge  = (a >= b);

endmodule

FILE: rtl/gbba_scan.sv
// Bitmap word scan: masks bits past the group size, finds the lowest clear bit.
// Depends on gbba_pkg.
module gbba_scan import gbba_pkg::*; (
  input  logic [WORD_BITS-1:0] data,
  input  logic [WCNT_W-1:0]    wcnt,
  input  logic [SIZE_W-1:0]    size,
  output scan_res_t            res
);

  logic [ACC_W-1:0]     base;
  logic [ACC_W-1:0]     left;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] seen;

  always_comb begin
    base = ACC_W'({wcnt, {BIT_W{1'b0}}});
    left = ACC_W'(size) - base;
    if (base >= ACC_W'(size)) begin
      mask = '0;
    end else if (left >= ACC_W'(WORD_BITS)) begin
      mask = ALL_ONES;
    end else begin
      mask = (WORD_BITS'(1) << left[BIT_W-1:0]) - WORD_BITS'(1);
    end
    seen = data | ~mask;
    res.found   = (seen != ALL_ONES);
    res.bit_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!seen[i]) begin
        res.bit_idx = BIT_W'(i);
      end
    end
  end

endmodule

FILE: rtl/group_bitmap_block_allocator.sv
// First-fit block allocator over per-group usage bitmaps, top level.
// Depends on gbba_pkg, gbba_if, gbba_ram, gbba_alu and gbba_scan.
//
// Usage:
//   in_if  (sink):   req_type (alloc or free) and block_number, valid/ready.
//   out_if (source): allocated_block and status, one item per request.
//   cfg_*:           write port for the group size (index 0) and
//                    active_groups (index 1); write only while idle.
// Reset clears the group counts at once, then a clearing pass writes every
// bitmap word to zero, during which in_if.ready stays low.
// Sequencing, one request at a time through one shared adder and one RAM port:
//   free:     a subtract step per group the block number lies past, then a
//             bitmap read and write; an out-of-range block finishes early.
//   allocate: a step per full group skipped, a RAM read then a scan per bitmap
//             word read, and a return to the group check per group left.
// The next request is taken in the cycle after a result is done.
// A finished item sits in the output register; the next request is taken
// while it waits. If out_if.ready is low when the following result is done,
// the sequencer holds in its final state until the register frees up.
module group_bitmap_block_allocator import gbba_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  gbba_in_if.sink          in_if,
  gbba_out_if.source       out_if,
  input  logic             cfg_we,
  input  logic             cfg_idx,
  input  logic [CFG_W-1:0] cfg_wdata
);

  state_t              state_r, state_nxt;
  logic [SIZE_W-1:0]   bpg_r;
  logic [AG_W-1:0]     ag_r;
  logic [CLR_W-1:0]    clr_r, clr_nxt;
  logic [GCNT_W-1:0]   gcnt_r, gcnt_nxt;
  logic [WCNT_W-1:0]   wcnt_r, wcnt_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [BLK_W-1:0]    res_blk_r, res_blk_nxt;
  status_t             res_st_r, res_st_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [BLK_W-1:0]    out_blk_r, out_blk_nxt;
  status_t             out_st_r, out_st_nxt;
  logic [CNT_W-1:0]    cnt_r [NUM_GROUPS];

  logic [SIZE_W-1:0]   eff_size;
  logic [GCNT_W-1:0]   eff_groups;
  logic [GRP_W-1:0]    g_idx;
  logic [CNT_W-1:0]    cur_cnt;
  logic                cnt_we;
  logic [CNT_W-1:0]    cnt_wv;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_wa, ram_ra;
  logic [WORD_BITS-1:0] ram_wd, ram_rd;

  logic                alu_sub;
  logic [ACC_W-1:0]    alu_a, alu_b, alu_res;
  logic                alu_ge;

  scan_res_t           scan;
  logic [WCNT_W-1:0]   wnext;

  gbba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .raddr (ram_ra),
    .rdata (ram_rd)
  );

  gbba_alu u_alu (
    .sub (alu_sub),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .ge  (alu_ge)
  );

  gbba_scan u_scan (
    .data (ram_rd),
    .wcnt (wcnt_r),
    .size (eff_size),
    .res  (scan)
  );

  assign eff_size   = (ACC_W'(bpg_r) > ACC_W'(GROUP_CAP)) ? SIZE_W'(GROUP_CAP) : bpg_r;
  assign eff_groups = (GCNT_W'(ag_r) > GCNT_W'(NUM_GROUPS)) ? GCNT_W'(NUM_GROUPS)
                                                          : GCNT_W'(ag_r);
  assign g_idx   = gcnt_r[GRP_W-1:0];
  assign cur_cnt = cnt_r[g_idx];
  assign wnext   = wcnt_r + WCNT_W'(1);

  assign in_if.ready            = (state_r == S_IDLE);
  assign out_if.valid           = out_valid_r;
  assign out_if.allocated_block = out_blk_r;
  assign out_if.status          = out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpg_r <= SIZE_W'(8192);
      ag_r  <= AG_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        CFG_GROUP_SIZE:    bpg_r <= cfg_wdata[SIZE_W-1:0];
        CFG_ACTIVE_GROUPS: ag_r  <= cfg_wdata[AG_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_GROUPS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cnt_we) begin
        cnt_r[g_idx] <= cnt_wv;
      end
    end
  end

  always_ff @(posedge clk) begin
    gcnt_r    <= gcnt_nxt;
    wcnt_r    <= wcnt_nxt;
    acc_r     <= acc_nxt;
    res_blk_r <= res_blk_nxt;
    res_st_r  <= res_st_nxt;
    out_blk_r <= out_blk_nxt;
    out_st_r  <= out_st_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    gcnt_nxt      = gcnt_r;
    wcnt_nxt      = wcnt_r;
    acc_nxt       = acc_r;
    res_blk_nxt   = res_blk_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r;
    out_blk_nxt   = out_blk_r;
    out_st_nxt    = out_st_r;
    cnt_we        = 1'b0;
    cnt_wv        = cur_cnt;
    ram_we        = 1'b0;
    ram_wa        = word_addr(g_idx, wcnt_r[WORD_W-1:0]);
    ram_wd        = ram_rd;
    ram_ra        = word_addr(g_idx, wcnt_r[WORD_W-1:0]);
    alu_sub       = 1'b0;
    alu_a         = acc_r;
    alu_b         = ACC_W'(eff_size);

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        ram_we  = 1'b1;
        ram_wa  = clr_r[ADDR_W-1:0];
        ram_wd  = '0;
        clr_nxt = clr_r + CLR_W'(1);
        if (clr_r == CLR_W'(RAM_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        gcnt_nxt    = '0;
        res_blk_nxt = '0;
        if (in_if.valid) begin
          if (in_if.req_type == REQ_FREE) begin
            acc_nxt = ACC_W'(in_if.block_number);
            if (eff_size == '0 || eff_groups == '0) begin
              res_st_nxt = ST_OUT_OF_RANGE;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_DIV;
            end
          end else begin
            acc_nxt   = '0;
            state_nxt = S_GRP;
          end
        end
      end
      S_DIV: begin
        alu_sub = 1'b1;
        if (alu_ge) begin
          if (gcnt_r + GCNT_W'(1) >= eff_groups) begin
            res_st_nxt = ST_OUT_OF_RANGE;
            state_nxt  = S_DONE;
          end else begin
            acc_nxt  = alu_res;
            gcnt_nxt = gcnt_r + GCNT_W'(1);
          end
        end else begin
          state_nxt = S_FREE_RD;
        end
      end
      S_FREE_RD: begin
        ram_ra    = word_addr(g_idx, acc_r[BIT_W +: WORD_W]);
        state_nxt = S_FREE_WR;
      end
      S_FREE_WR: begin
        ram_we = 1'b1;
        ram_wa = word_addr(g_idx, acc_r[BIT_W +: WORD_W]);
        ram_wd = ram_rd & ~(WORD_BITS'(1) << acc_r[BIT_W-1:0]);
        cnt_we = 1'b1;
        cnt_wv = (cur_cnt != '0) ? (cur_cnt - CNT_W'(1)) : cur_cnt;
        res_st_nxt = ST_OK;
        state_nxt  = S_DONE;
      end
      S_GRP: begin
        wcnt_nxt = '0;
        if (gcnt_r >= eff_groups) begin
          res_st_nxt = ST_NO_SPACE;
          state_nxt  = S_DONE;
        end else if (cur_cnt >= CNT_W'(eff_size)) begin
          acc_nxt  = alu_res;
          gcnt_nxt = gcnt_r + GCNT_W'(1);
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (scan.found) begin
          alu_b = ACC_W'({wcnt_r, scan.bit_idx});
          if (alu_res[ACC_W-1:BLK_W] != '0) begin
            res_st_nxt = ST_NO_SPACE;
          end else begin
            ram_we      = 1'b1;
            ram_wd      = ram_rd | (WORD_BITS'(1) << scan.bit_idx);
            cnt_we      = 1'b1;
            cnt_wv      = (cur_cnt != COUNT_MAX) ? (cur_cnt + CNT_W'(1)) : cur_cnt;
            res_blk_nxt = alu_res[BLK_W-1:0];
            res_st_nxt  = ST_OK;
          end
          state_nxt = S_DONE;
        end else if (ACC_W'({wnext, {BIT_W{1'b0}}}) >= ACC_W'(eff_size)) begin
          acc_nxt   = alu_res;
          gcnt_nxt  = gcnt_r + GCNT_W'(1);
          state_nxt = S_GRP;
        end else begin
          wcnt_nxt  = wnext;
          state_nxt = S_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_blk_nxt   = res_blk_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result item raised outside the final state");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> (state_r != S_IDLE && state_r != S_CLR))
    else $error("accepted item did not start the sequencer");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLR || state_r == S_FREE_WR || state_r == S_CHK))
    else $error("bitmap written outside clear, free or allocate");

  a_cnt_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_we |-> ram_we)
    else $error("group count changed without a bitmap update");

endmodule

FILE: sim/tb.sv
// Testbench for group_bitmap_block_allocator: random and directed alloc/free traffic
// with a bitmap/count predictor checked against every result item.
// Depends on gbba_pkg, gbba_if and the design under test from the rtl folder.
module tb;
  import gbba_pkg::*;

  typedef struct packed {
    req_t             req;
    logic [BLK_W-1:0] blk;
  } request_t;

  typedef struct packed {
    logic [BLK_W-1:0] blk;
    status_t          st;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cfg_reg_t cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;

  gbba_in_if  in_ch ();
  gbba_out_if out_ch ();

  group_bitmap_block_allocator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [WORD_BITS-1:0] bitmap_q [RAM_DEPTH];
  logic [CNT_W-1:0]     used_cnt [NUM_GROUPS];
  logic [SIZE_W-1:0]    cfg_bpg;
  logic [AG_W-1:0]      cfg_groups;

  request_t request_q [$];
  reply_t   pending_replies [$];
  int       mismatches = 0;
  int       results_seen = 0;
  bit       in_taken = 0;

  int burst_left = 1;
  int gap_left = 0;
  int hold_left = 0;
  bit long_hold_done = 0;
  int rx_mode = 0;
  int mode_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int eff_size();
    int cap = WORDS_PER_GROUP * WORD_BITS;
    return (int'(cfg_bpg) > cap) ? cap : int'(cfg_bpg);
  endfunction

  function automatic int eff_groups();
    return (int'(cfg_groups) > NUM_GROUPS) ? NUM_GROUPS : int'(cfg_groups);
  endfunction

  // first fit: first group with room by count, first word with a clear bit in range
  function automatic reply_t predict_alloc();
    int size, groups, words, idx, base, b, blk;
    logic [WORD_BITS-1:0] mask, seen;
    reply_t r;
    size = eff_size();
    groups = eff_groups();
    words = (size + WORD_BITS - 1) / WORD_BITS;
    r.blk = '0;
    r.st = ST_NO_SPACE;
    for (int g = 0; g < groups; g++) begin
      if (int'(used_cnt[g]) >= size) continue;
      for (int w = 0; w < words; w++) begin
        idx = g * WORDS_PER_GROUP + w;
        base = w * WORD_BITS;
        if (base >= size) mask = '0;
        else if (size - base >= WORD_BITS) mask = '1;
        else mask = (32'h1 << (size - base)) - 32'h1;
        seen = bitmap_q[idx] | ~mask;
        if (seen == ALL_ONES) continue;
        b = 0;
        while (seen[b]) b++;
        blk = g * size + base + b;
        if (blk > 65535) return r;
        bitmap_q[idx][b] = 1'b1;
        if (used_cnt[g] != COUNT_MAX) used_cnt[g] = used_cnt[g] + 1'b1;
        r.blk = BLK_W'(blk);
        r.st = ST_OK;
        return r;
      end
    end
    return r;
  endfunction

  function automatic reply_t predict_free(logic [BLK_W-1:0] blk);
    int size, groups, g, off;
    reply_t r;
    size = eff_size();
    groups = eff_groups();
    r.blk = '0;
    if (size == 0 || int'(blk) >= groups * size) begin
      r.st = ST_OUT_OF_RANGE;
    end else begin
      g = int'(blk) / size;
      off = int'(blk) % size;
      bitmap_q[g * WORDS_PER_GROUP + off / WORD_BITS][off % WORD_BITS] = 1'b0;
      if (used_cnt[g] != '0) used_cnt[g] = used_cnt[g] - 1'b1;
      r.st = ST_OK;
    end
    return r;
  endfunction

  function automatic void push_req(req_t req, logic [BLK_W-1:0] blk);
    request_t item;
    item.req = req;
    item.blk = blk;
    request_q.push_back(item);
  endfunction

  // frees mostly land near the start of some group, where first fit hands out blocks
  task automatic add_random(int n, int alloc_pct);
    int size, groups, limit, pick;
    logic [BLK_W-1:0] blk;
    size = eff_size();
    groups = eff_groups();
    limit = size * groups;
    for (int i = 0; i < n; i++) begin
      blk = BLK_W'($urandom_range(0, 65535));
      if ($urandom_range(0, 99) < alloc_pct) begin
        push_req(REQ_ALLOC, blk);
      end else begin
        pick = $urandom_range(0, 9);
        if (limit > 0 && pick == 1)
          blk = (limit > 65535) ? 16'hFFFF : BLK_W'(limit);
        else if (limit > 0 && pick == 2)
          blk = BLK_W'(limit - 1);
        else if (limit > 0 && pick > 2)
          blk = BLK_W'($urandom_range(0, groups - 1) * size +
                       $urandom_range(0, ((size < 64) ? size : 64) - 1));
        push_req(REQ_FREE, blk);
      end
    end
  endtask

  task automatic drain();
    while (request_q.size() != 0 || in_ch.valid || pending_replies.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    if (idx == CFG_GROUP_SIZE) cfg_bpg = value[SIZE_W-1:0];
    else cfg_groups = value[AG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [CFG_W-1:0] bpg, logic [CFG_W-1:0] groups);
    drain();
    write_reg(CFG_GROUP_SIZE, bpg);
    write_reg(CFG_ACTIVE_GROUPS, groups);
  endtask

  // sender: bursts of items with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left--;
      end else if (request_q.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.req_type <= request_q[0].req;
        in_ch.block_number <= request_q[0].blk;
        void'(request_q.pop_front());
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: stall modes of random length, plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (!long_hold_done && results_seen >= 200 && in_ch.valid &&
                 request_q.size() >= 60) begin
      long_hold_done = 1'b1;
      hold_left = 400;
      out_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // result check, then prediction for the item taken at this edge
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_replies.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result item: block %0d status %0d", $time,
                   out_ch.allocated_block, out_ch.status);
        end else begin
          if (out_ch.allocated_block !== pending_replies[0].blk) begin
            mismatches++;
            $display("%0t: allocated_block mismatch: expected %0d actual %0d", $time,
                     pending_replies[0].blk, out_ch.allocated_block);
          end
          if (out_ch.status !== pending_replies[0].st) begin
            mismatches++;
            $display("%0t: status mismatch: expected %0d actual %0d", $time,
                     pending_replies[0].st, out_ch.status);
          end
          void'(pending_replies.pop_front());
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        in_taken = 1'b1;
        if (in_ch.req_type == REQ_ALLOC) pending_replies.push_back(predict_alloc());
        else pending_replies.push_back(predict_free(in_ch.block_number));
      end
    end
  end

  initial begin
    #60_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    for (int i = 0; i < RAM_DEPTH; i++) bitmap_q[i] = '0;
    for (int i = 0; i < NUM_GROUPS; i++) used_cnt[i] = '0;
    cfg_bpg = SIZE_W'(8192);
    cfg_groups = AG_W'(8);
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_GROUP_SIZE;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset sizes: basic grants, double frees, top block number
    push_req(REQ_ALLOC, 16'hFFFF);
    push_req(REQ_ALLOC, 16'h0000);
    push_req(REQ_ALLOC, 16'h5A5A);
    push_req(REQ_FREE, 16'd1);
    push_req(REQ_ALLOC, 16'h0000);
    push_req(REQ_FREE, 16'd1);
    push_req(REQ_FREE, 16'd1);
    push_req(REQ_FREE, 16'hFFFF);
    push_req(REQ_FREE, 16'd0);
    push_req(REQ_ALLOC, 16'h0000);
    add_random(150, 55);

    set_config(14'd32, 14'd1);
    add_random(150, 60);

    // zero group size; group register write with junk in the upper bits
    set_config(14'd0, 14'h3FF3);
    push_req(REQ_ALLOC, 16'h0000);
    push_req(REQ_FREE, 16'd0);
    add_random(20, 50);

    // tiny groups, group count above the number of groups
    set_config(14'd5, 14'd15);
    push_req(REQ_ALLOC, 16'h0000);
    push_req(REQ_FREE, 16'd39);
    push_req(REQ_FREE, 16'd40);
    add_random(150, 60);

    set_config(14'd100, 14'd0);
    push_req(REQ_ALLOC, 16'h0000);
    push_req(REQ_FREE, 16'd0);
    add_random(20, 50);

    // oversized group acts as the full bitmap size
    set_config(14'h3FFF, 14'd2);
    push_req(REQ_FREE, 16'd16384);
    push_req(REQ_FREE, 16'd16383);
    push_req(REQ_ALLOC, 16'h0000);
    add_random(150, 50);

    set_config(14'd1, 14'd8);
    add_random(100, 60);

    set_config(14'd33, 14'd4);
    add_random(200, 60);

    set_config(14'd4000, 14'd7);
    add_random(150, 70);

    set_config(14'd8191, 14'd8);
    add_random(150, 50);

    set_config(14'd77, 14'd3);
    add_random(150, 55);

    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
